// ----- rtl/core/modem_event_stream_parser_top_assert.svh -----
// Assertion macros for the modem event stream parser.
// Used by modem_event_stream_parser_top; expects clk and rst_n in scope.
`ifndef MODEM_EVENT_STREAM_PARSER_TOP_ASSERT_SVH
`define MODEM_EVENT_STREAM_PARSER_TOP_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define MESP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define MESP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/mesp_pkg.sv -----
// Package for the modem event stream parser: event and link codes,
// match texts and small per-byte helper functions. No dependencies.
package mesp_pkg;

  // event kinds
  localparam logic [2:0] EV_PAYLOAD   = 3'd0;
  localparam logic [2:0] EV_CONNECT   = 3'd1;
  localparam logic [2:0] EV_CLOSE     = 3'd2;
  localparam logic [2:0] EV_LINK_UP   = 3'd3;
  localparam logic [2:0] EV_LINK_DOWN = 3'd4;
  localparam logic [2:0] EV_MOD_READY = 3'd5;

  // link modes
  localparam logic [1:0] LINK_NONE  = 2'd0;
  localparam logic [1:0] LINK_READY = 2'd1;
  localparam logic [1:0] LINK_UP    = 2'd2;
  localparam logic [1:0] LINK_DOWN  = 2'd3;

  // characters
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_L     = 8'h4C;

  localparam logic [11:0] FRAME_LIMIT = 12'd2048;
  localparam logic [11:0] LEN_SAT     = 12'hFFF;
  localparam int          LINE_MIN    = 4;

  // prefix texts, right aligned, first character in the highest used byte
  localparam logic [239:0] TXT_GOT_IP = "WIFI GOT IP";
  localparam logic [239:0] TXT_IPD    = "+IPD,";
  localparam logic [239:0] TXT_DISC   = "WIFI DISCONNECT";
  localparam logic [239:0] TXT_CONN   = "WIFI CONNECTED";
  localparam logic [239:0] TXT_BANNER =
    240'h41692D5468696E6B657220546563686E6F6C6F677920436F2E2C4C74642E;

  localparam logic [4:0] TXT_GOT_IP_LEN = 5'd11;
  localparam logic [4:0] TXT_IPD_LEN    = 5'd5;
  localparam logic [4:0] TXT_DISC_LEN   = 5'd15;
  localparam logic [4:0] TXT_CONN_LEN   = 5'd14;
  localparam logic [4:0] TXT_BANNER_LEN = 5'd30;

  // socket id accumulator: low three bits plus a flag once the value reached 8
  typedef struct packed {
    logic       big;
    logic [2:0] val;
  } sock_acc_t;

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic [7:0] txt_byte(input logic [239:0] txt, input logic [4:0] len,
                                          input logic [4:0] i);
    logic [4:0] k;
    k = len - 5'd1 - i;
    if (i < len) begin
      txt_byte = txt[{k, 3'b000} +: 8];
    end else begin
      txt_byte = 8'h00;
    end
  endfunction

  // running prefix compare; positions past the text leave the flag alone
  function automatic logic pfx_step(input logic flag, input logic [239:0] txt,
                                    input logic [4:0] len, input logic [4:0] pos_lo,
                                    input logic pos_ge32, input logic [7:0] b);
    pfx_step = flag & (pos_ge32 | (pos_lo >= len) | (b == txt_byte(txt, len, pos_lo)));
  endfunction

  function automatic sock_acc_t sock_acc(input sock_acc_t a, input logic [7:0] c);
    logic [6:0] t;
    t = {4'b0000, a.val} * 7'd10 + {3'b000, c[3:0]};
    sock_acc.big = a.big | (t >= 7'd8);
    sock_acc.val = t[2:0];
  endfunction

  // decimal length accumulator, saturates at 4095 (anything that large clamps anyway)
  function automatic logic [11:0] len_acc(input logic [11:0] v, input logic [7:0] c);
    logic [15:0] t;
    t = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {12'h000, c[3:0]};
    len_acc = (t > {4'h0, LEN_SAT}) ? LEN_SAT : t[11:0];
  endfunction

endpackage

// ----- rtl/core/modem_event_stream_parser_top.sv -----
// Modem event stream parser, top level: header line matching, frame
// payload routing and link tracking. Depends on mesp_pkg and the assert header.
//
//   channel  | ports                                    | dir
//   ---------+------------------------------------------+-----
//   input    | in_valid, in_ready, in_rx_byte           | in
//   result   | out_valid, out_ready, out_event_kind,    | out
//            | out_socket_id, out_data_byte,            |
//            | out_last_of_frame, out_link_status       |
//   config   | cfg_wr_en, cfg_wr_data (max_payload)     | in
//
// One byte per cycle while the result register is free or drains. A byte lands
// in the input register, is parsed by the per-byte match logic and its event
// (if any) is loaded into the result register.
// Synchronous active-low reset clears the line, frame, link and socket state;
// max_payload resets to 2048. No clearing pass.
// A stalled result freezes parsing; the input register still takes one byte.
`include "modem_event_stream_parser_top_assert.svh"

module modem_event_stream_parser_top #(
  parameter int SOCKET_COUNT = 5,
  parameter int LINE_DEPTH   = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_event_kind,
  output logic [2:0]  out_socket_id,
  output logic [7:0]  out_data_byte,
  output logic        out_last_of_frame,
  output logic [1:0]  out_link_status,
  input  logic        cfg_wr_en,
  input  logic [11:0] cfg_wr_data
);
  import mesp_pkg::*;

  // CW holds any line position (max LINE_DEPTH-2), NW holds a line length + 2
  localparam int CW = $clog2(LINE_DEPTH);
  localparam int NW = CW + 1;
  localparam int SW = (SOCKET_COUNT > 1) ? $clog2(SOCKET_COUNT) : 1;
  localparam logic [3:0] SOCK_LIM = 4'(SOCKET_COUNT);

  // frame-id parser codes
  localparam logic [2:0] IP_ID0  = 3'd0;  // want first id digit
  localparam logic [2:0] IP_ID   = 3'd1;  // id digits, comma ends
  localparam logic [2:0] IP_LEN0 = 3'd2;  // want first length digit
  localparam logic [2:0] IP_LEN  = 3'd3;  // length digits
  localparam logic [2:0] IP_OK   = 3'd4;  // length done
  localparam logic [2:0] IP_BAD  = 3'd5;

  // input register
  logic       in_vld_r;
  logic [7:0] in_byte_r;

  // configuration
  logic [11:0] cfg_mp_r;

  // per-line state
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          run_r, run_nxt;       // every byte so far is a digit
  logic [CW-1:0] d_r, d_nxt;           // position of first non-digit
  logic [7:0]    cap_r, cap_nxt;       // byte two past the digit run
  logic [7:0]    hist_r [0:5];         // previous six bytes, [5] oldest
  sock_acc_t     nid_r, nid_nxt;       // leading number of the line
  logic          m_gotip_r, m_gotip_nxt;
  logic          m_ipd_r, m_ipd_nxt;
  logic          m_disc_r, m_disc_nxt;
  logic          m_conn_r, m_conn_nxt;
  logic          m_banner_r, m_banner_nxt;
  logic [2:0]    ist_r, ist_nxt;
  sock_acc_t     iid_r, iid_nxt;
  logic [11:0]   ilen_r, ilen_nxt;

  // frame and link state
  logic                    pay_r, pay_nxt;
  logic [SW-1:0]           pay_sock_r, pay_sock_nxt;
  logic [11:0]             pay_left_r, pay_left_nxt;
  logic [1:0]              link_r, link_nxt;
  logic [SOCKET_COUNT-1:0] in_use_r, in_use_nxt;
  logic [SOCKET_COUNT-1:0] readable_r, readable_nxt;

  // result register
  logic       out_valid_r, out_valid_nxt;
  logic [2:0] out_kind_r, out_kind_nxt;
  logic [2:0] out_sock_r, out_sock_nxt;
  logic [7:0] out_data_r, out_data_nxt;
  logic       out_last_r, out_last_nxt;
  logic [1:0] out_link_r, out_link_nxt;

  // handshake: parsing advances whenever the result register is free or drains
  logic adv, step;
  assign adv      = !out_valid_r || out_ready;
  assign step     = in_vld_r && adv;
  assign in_ready = !in_vld_r || adv;

  // per-byte decode
  logic [7:0]    b;
  logic          dig;
  logic [NW-1:0] pos_w, n_w, d_f, d_f2;
  logic          pos_ge32, pos_ge5;
  logic [4:0]    pos_lo;
  logic          eol, long_enough;
  logic          run_f;
  logic [7:0]    c_sel;
  logic          id_ok, iid_ok, ipd_form;
  logic [11:0]   mp_eff, len_clamp;
  logic [SW-1:0] nsock, isock;

  always_comb begin
    b        = in_byte_r;
    dig      = is_digit(b);
    pos_w    = {1'b0, cnt_r};
    n_w      = pos_w + NW'(1);
    pos_ge32 = (pos_w >= NW'(32));
    pos_ge5  = (pos_w >= NW'(5));
    pos_lo   = cnt_r[4:0];
    eol      = (b == CH_NL) || (b == CH_COLON) || (cnt_r == CW'(LINE_DEPTH - 2));
    long_enough = (n_w >= NW'(LINE_MIN));

    // prefix compares, current byte included
    m_gotip_nxt  = pfx_step(m_gotip_r, TXT_GOT_IP, TXT_GOT_IP_LEN, pos_lo, pos_ge32, b);
    m_ipd_nxt    = pfx_step(m_ipd_r, TXT_IPD, TXT_IPD_LEN, pos_lo, pos_ge32, b);
    m_disc_nxt   = pfx_step(m_disc_r, TXT_DISC, TXT_DISC_LEN, pos_lo, pos_ge32, b);
    m_conn_nxt   = pfx_step(m_conn_r, TXT_CONN, TXT_CONN_LEN, pos_lo, pos_ge32, b);
    m_banner_nxt = pfx_step(m_banner_r, TXT_BANNER, TXT_BANNER_LEN, pos_lo, pos_ge32, b);

    // leading digit run of a notice line
    run_f   = run_r && dig;
    run_nxt = run_f;
    d_nxt   = (run_r && !dig) ? cnt_r : d_r;
    nid_nxt = run_f ? sock_acc(nid_r, b) : nid_r;
    cap_nxt = (!run_r && (pos_w == {1'b0, d_r} + NW'(2))) ? b : cap_r;
    if (run_r) begin
      d_f = dig ? n_w : pos_w;
    end else begin
      d_f = {1'b0, d_r};
    end
    d_f2 = d_f + NW'(2);
    // the scan is capped at length-9 on long lines, so the deciding byte
    // is then six bytes back from the current one
    if ((n_w >= NW'(9)) && (d_f > n_w - NW'(9))) begin
      c_sel = hist_r[5];
    end else if (d_f2 < n_w) begin
      c_sel = (d_f2 == pos_w) ? b : cap_r;
    end else begin
      c_sel = 8'h00;
    end
    id_ok = !nid_nxt.big && ({1'b0, nid_nxt.val} < SOCK_LIM);
    nsock = SW'(nid_nxt.val);

    // frame header "+IPD,<id>,<len>"
    ist_nxt  = ist_r;
    iid_nxt  = iid_r;
    ilen_nxt = ilen_r;
    if (pos_ge5) begin
      case (ist_r)
        IP_ID0: begin
          if (dig) begin
            ist_nxt = IP_ID;
            iid_nxt = sock_acc(iid_r, b);
          end else begin
            ist_nxt = IP_BAD;
          end
        end
        IP_ID: begin
          if (dig) begin
            iid_nxt = sock_acc(iid_r, b);
          end else if (b == CH_COMMA) begin
            ist_nxt = IP_LEN0;
          end else begin
            ist_nxt = IP_BAD;
          end
        end
        IP_LEN0: begin
          if (dig) begin
            ist_nxt  = IP_LEN;
            ilen_nxt = len_acc(ilen_r, b);
          end else begin
            ist_nxt = IP_BAD;
          end
        end
        IP_LEN: begin
          if (dig) begin
            ilen_nxt = len_acc(ilen_r, b);
          end else begin
            ist_nxt = IP_OK;
          end
        end
        IP_OK:   ist_nxt = IP_OK;
        default: ist_nxt = IP_BAD;
      endcase
    end
    ipd_form = (ist_nxt == IP_LEN) || (ist_nxt == IP_OK);
    iid_ok   = !iid_nxt.big && ({1'b0, iid_nxt.val} < SOCK_LIM);
    isock    = SW'(iid_nxt.val);

    if (cfg_mp_r == 12'd0) begin
      mp_eff = 12'd1;
    end else if (cfg_mp_r > FRAME_LIMIT) begin
      mp_eff = FRAME_LIMIT;
    end else begin
      mp_eff = cfg_mp_r;
    end
    len_clamp = (ilen_nxt > mp_eff) ? mp_eff : ilen_nxt;

    cnt_nxt = cnt_r + CW'(1);
  end

  // step: state updates and the result for the byte in the input register
  logic emit;

  always_comb begin
    pay_nxt      = pay_r;
    pay_sock_nxt = pay_sock_r;
    pay_left_nxt = pay_left_r;
    link_nxt     = link_r;
    in_use_nxt   = in_use_r;
    readable_nxt = readable_r;
    emit         = 1'b0;
    out_kind_nxt = out_kind_r;
    out_sock_nxt = 3'd0;
    out_data_nxt = 8'h00;
    out_last_nxt = 1'b0;

    if (pay_r) begin
      emit         = 1'b1;
      out_kind_nxt = EV_PAYLOAD;
      out_sock_nxt = 3'(pay_sock_r);
      out_data_nxt = b;
      pay_left_nxt = pay_left_r - 12'd1;
      if (pay_left_r == 12'd1) begin
        out_last_nxt             = 1'b1;
        pay_nxt                  = 1'b0;
        readable_nxt[pay_sock_r] = 1'b1;
      end
    end else if (eol && long_enough) begin
      if (m_gotip_nxt && (n_w >= NW'(TXT_GOT_IP_LEN))) begin
        link_nxt     = LINK_UP;
        emit         = 1'b1;
        out_kind_nxt = EV_LINK_UP;
      end else if (d_f != NW'(0)) begin
        // socket notice "<id>,CONNECT" / "<id>,CLOSED"
        if (id_ok && (c_sel == CH_O)) begin
          in_use_nxt[nsock]   = 1'b1;
          readable_nxt[nsock] = 1'b0;
          emit                = 1'b1;
          out_kind_nxt        = EV_CONNECT;
          out_sock_nxt        = 3'(nsock);
        end else if (id_ok && (c_sel == CH_L)) begin
          in_use_nxt[nsock]   = 1'b0;
          readable_nxt[nsock] = 1'b0;
          emit                = 1'b1;
          out_kind_nxt        = EV_CLOSE;
          out_sock_nxt        = 3'(nsock);
        end
      end else if (m_ipd_nxt && (n_w >= NW'(TXT_IPD_LEN))) begin
        if (ipd_form && iid_ok) begin
          if (len_clamp == 12'd0) begin
            readable_nxt[isock] = 1'b1;
          end else begin
            pay_nxt      = 1'b1;
            pay_sock_nxt = isock;
            pay_left_nxt = len_clamp;
          end
        end
      end else if (m_disc_nxt && (n_w >= NW'(TXT_DISC_LEN))) begin
        link_nxt     = LINK_DOWN;
        emit         = 1'b1;
        out_kind_nxt = EV_LINK_DOWN;
      end else if (m_conn_nxt && (n_w >= NW'(TXT_CONN_LEN))) begin
        emit = 1'b0;  // association notice, no event
      end else if (m_banner_nxt && (n_w >= NW'(TXT_BANNER_LEN))) begin
        link_nxt     = LINK_READY;
        emit         = 1'b1;
        out_kind_nxt = EV_MOD_READY;
      end
    end
    out_link_nxt  = link_nxt;
    out_valid_nxt = adv ? (step && emit) : out_valid_r;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r    <= 1'b0;
      cfg_mp_r    <= FRAME_LIMIT;
      cnt_r       <= '0;
      run_r       <= 1'b1;
      d_r         <= '0;
      nid_r       <= '0;
      m_gotip_r   <= 1'b1;
      m_ipd_r     <= 1'b1;
      m_disc_r    <= 1'b1;
      m_conn_r    <= 1'b1;
      m_banner_r  <= 1'b1;
      ist_r       <= IP_ID0;
      iid_r       <= '0;
      ilen_r      <= '0;
      pay_r       <= 1'b0;
      pay_sock_r  <= '0;
      pay_left_r  <= '0;
      link_r      <= LINK_NONE;
      in_use_r    <= '0;
      readable_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (cfg_wr_en) begin
        cfg_mp_r <= cfg_wr_data;
      end
      out_valid_r <= out_valid_nxt;
      if (step) begin
        pay_r      <= pay_nxt;
        pay_sock_r <= pay_sock_nxt;
        pay_left_r <= pay_left_nxt;
        link_r     <= link_nxt;
        in_use_r   <= in_use_nxt;
        readable_r <= readable_nxt;
        if (!pay_r) begin
          if (eol) begin
            cnt_r      <= '0;
            run_r      <= 1'b1;
            d_r        <= '0;
            nid_r      <= '0;
            m_gotip_r  <= 1'b1;
            m_ipd_r    <= 1'b1;
            m_disc_r   <= 1'b1;
            m_conn_r   <= 1'b1;
            m_banner_r <= 1'b1;
            ist_r      <= IP_ID0;
            iid_r      <= '0;
            ilen_r     <= '0;
          end else begin
            cnt_r      <= cnt_nxt;
            run_r      <= run_nxt;
            d_r        <= d_nxt;
            nid_r      <= nid_nxt;
            m_gotip_r  <= m_gotip_nxt;
            m_ipd_r    <= m_ipd_nxt;
            m_disc_r   <= m_disc_nxt;
            m_conn_r   <= m_conn_nxt;
            m_banner_r <= m_banner_nxt;
            ist_r      <= ist_nxt;
            iid_r      <= iid_nxt;
            ilen_r     <= ilen_nxt;
          end
        end
      end
    end
  end

  // data registers, no reset
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_byte_r <= in_rx_byte;
    end
    if (step && !pay_r) begin
      cap_r     <= cap_nxt;
      hist_r[0] <= b;
      for (int i = 1; i < 6; i++) begin
        hist_r[i] <= hist_r[i-1];
      end
    end
    if (step && emit) begin
      out_kind_r <= out_kind_nxt;
      out_sock_r <= out_sock_nxt;
      out_data_r <= out_data_nxt;
      out_last_r <= out_last_nxt;
      out_link_r <= out_link_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_event_kind    = out_kind_r;
  assign out_socket_id     = out_sock_r;
  assign out_data_byte     = out_data_r;
  assign out_last_of_frame = out_last_r;
  assign out_link_status   = out_link_r;

  // a frame in progress always has bytes left
  `MESP_ASSERT_NOW(a_pay_left_nz, pay_r, pay_left_r != 12'd0, "frame active with zero left")
  // a pending connect event matches the socket table
  `MESP_ASSERT_NOW(a_conn_tbl, out_valid_r && (out_kind_r == EV_CONNECT),
    in_use_r[out_sock_r[SW-1:0]] && !readable_r[out_sock_r[SW-1:0]],
    "connect event without socket in use")
  // a pending close event matches the socket table
  `MESP_ASSERT_NOW(a_close_tbl, out_valid_r && (out_kind_r == EV_CLOSE),
    !in_use_r[out_sock_r[SW-1:0]] && !readable_r[out_sock_r[SW-1:0]],
    "close event with socket still set")
  // last payload byte ends the frame and marks the socket readable
  `MESP_ASSERT_NOW(a_last_done, out_valid_r && (out_kind_r == EV_PAYLOAD) && out_last_r,
    !pay_r && readable_r[out_sock_r[SW-1:0]], "frame end not recorded")
  // a newline outside a frame restarts the line
  `MESP_ASSERT_NEXT(a_nl_restart, step && !pay_r && (in_byte_r == CH_NL),
    cnt_r == '0, "line not restarted after newline")

endmodule

// ----- tb/sv/modem_event_stream_parser_top_tb.sv -----
// Self-checking testbench for modem_event_stream_parser_top: directed and random
// byte streams, checked against an in-bench parser model. Depends on mesp_pkg and the RTL.
module modem_event_stream_parser_top_tb;
  import mesp_pkg::*;

  localparam int SOCKETS      = 5;
  localparam int LINE_CAP     = 64;
  localparam int STALL_LIMIT  = 5000;  // cycles with no transfer on either channel
  localparam int HOLD_CYCLES  = 400;   // long receiver hold-off in the pressure test
  localparam int DRAIN_CYCLES = 4;     // settling margin for the input and result registers

  localparam logic [7:0] CH_CR = 8'h0D;

  // header texts, right aligned, first character in the highest used byte
  localparam logic [239:0] PFX_GOT_IP = "WIFI GOT IP";
  localparam logic [239:0] PFX_IPD    = "+IPD,";
  localparam logic [239:0] PFX_DISC   = "WIFI DISCONNECT";
  localparam logic [239:0] PFX_CONN   = "WIFI CONNECTED";
  localparam logic [239:0] BANNER_TXT =
    240'h41692D5468696E6B657220546563686E6F6C6F677920436F2E2C4C74642E;
  localparam int BANNER_LEN = 30;

  // one result transfer, packed in port order
  typedef struct packed {
    logic [2:0] kind;
    logic [2:0] sock;
    logic [7:0] data;
    logic       last;
    logic [1:0] link;
  } parser_event_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_event_kind;
  logic [2:0]  out_socket_id;
  logic [7:0]  out_data_byte;
  logic        out_last_of_frame;
  logic [1:0]  out_link_status;
  logic        cfg_wr_en;
  logic [11:0] cfg_wr_data;

  modem_event_stream_parser_top #(
    .SOCKET_COUNT(SOCKETS),
    .LINE_DEPTH  (LINE_CAP)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_event_kind   (out_event_kind),
    .out_socket_id    (out_socket_id),
    .out_data_byte    (out_data_byte),
    .out_last_of_frame(out_last_of_frame),
    .out_link_status  (out_link_status),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  // ---------------------------------------------------------------------------
  // Bench bookkeeping
  // ---------------------------------------------------------------------------
  parser_event_t pending_events[$];   // events predicted but not yet seen at the output
  int unsigned   err_count;
  int unsigned   bytes_sent;
  int unsigned   results_checked;
  int unsigned   sender_idle_pct;     // chance per cycle that the sender inserts a gap
  int unsigned   receiver_idle_pct;   // chance per cycle that out_ready is low
  int unsigned   hold_reqs;           // long hold-offs asked of the receiver so far

  // ---------------------------------------------------------------------------
  // Parser model state: line buffer, frame tracking, link and socket flags
  // ---------------------------------------------------------------------------
  logic [7:0]  line_buf [LINE_CAP];
  int unsigned line_len;
  bit          frame_active;
  int unsigned frame_sock;
  int unsigned frame_left;
  logic [1:0]  link_now;
  bit          sock_open  [SOCKETS];
  bit          sock_ready [SOCKETS];
  logic [11:0] max_payload_reg;

  function automatic void reset_model();
    foreach (line_buf[i]) line_buf[i] = 8'h00;
    line_len        = 0;
    frame_active    = 1'b0;
    frame_sock      = 0;
    frame_left      = 0;
    link_now        = LINK_NONE;
    foreach (sock_open[i]) begin
      sock_open[i]  = 1'b0;
      sock_ready[i] = 1'b0;
    end
    max_payload_reg = 12'd2048;
  endfunction

  // positions at or past the current line length read as zero
  function automatic logic [7:0] line_at(int unsigned i);
    if (i < line_len && i < LINE_CAP) return line_buf[i];
    return 8'h00;
  endfunction

  function automatic bit is_dec(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic bit line_starts(logic [239:0] txt, int n);
    for (int i = 0; i < n; i++) begin
      if (line_at(i) != txt[(n - 1 - i) * 8 +: 8]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // decimal run at pos, saturating at 65535; returns the digit count
  function automatic int unsigned scan_dec(inout int unsigned pos, output int unsigned val);
    int unsigned cnt;
    cnt = 0;
    val = 0;
    while (pos < LINE_CAP && is_dec(line_at(pos))) begin
      val = val * 10 + 32'(line_at(pos) & 8'h0F);
      if (val > 65535) val = 65535;
      pos++;
      cnt++;
    end
    return cnt;
  endfunction

  function automatic parser_event_t form_event(logic [2:0] kind, int unsigned sock,
                                               logic [7:0] data, bit last);
    parser_event_t ev;
    ev.kind = kind;
    ev.sock = sock[2:0];
    ev.data = data;
    ev.last = last;
    ev.link = link_now;
    return ev;
  endfunction

  // classify a finished header line; returns 1 when it yields an event
  function automatic bit classify_line(output parser_event_t ev);
    int unsigned n, pos, id, len, lim, idx, mp;
    logic [7:0]  c;
    ev = '0;
    n  = line_len;
    if (n < 4) return 1'b0;
    if (line_starts(PFX_GOT_IP, 11)) begin
      link_now = LINK_UP;
      ev = form_event(EV_LINK_UP, 0, 8'h00, 1'b0);
      return 1'b1;
    end
    if (is_dec(line_at(0))) begin
      // socket notice: the byte two past the end of the digit scan decides
      lim = (n >= 9) ? n - 9 : 32'hFFFF_FFFF;
      idx = 0;
      while (idx < LINE_CAP && is_dec(line_at(idx)) && idx < lim) idx++;
      c   = line_at(idx + 2);
      pos = 0;
      void'(scan_dec(pos, id));
      if (id >= SOCKETS) return 1'b0;
      if (c == CH_O) begin
        sock_open[id]  = 1'b1;
        sock_ready[id] = 1'b0;
        ev = form_event(EV_CONNECT, id, 8'h00, 1'b0);
        return 1'b1;
      end
      if (c == CH_L) begin
        sock_open[id]  = 1'b0;
        sock_ready[id] = 1'b0;
        ev = form_event(EV_CLOSE, id, 8'h00, 1'b0);
        return 1'b1;
      end
      return 1'b0;
    end
    if (line_starts(PFX_IPD, 5)) begin
      pos = 5;
      if (scan_dec(pos, id) == 0) return 1'b0;
      if (line_at(pos) != CH_COMMA) return 1'b0;
      pos++;
      if (scan_dec(pos, len) == 0) return 1'b0;
      if (id >= SOCKETS) return 1'b0;
      mp = 32'(max_payload_reg);
      if (mp == 0) mp = 1;
      if (mp > 2048) mp = 2048;
      if (len > mp) len = mp;
      if (len == 0) begin
        sock_ready[id] = 1'b1;
        return 1'b0;
      end
      frame_active = 1'b1;
      frame_sock   = id;
      frame_left   = len;
      return 1'b0;
    end
    if (line_starts(PFX_DISC, 15)) begin
      link_now = LINK_DOWN;
      ev = form_event(EV_LINK_DOWN, 0, 8'h00, 1'b0);
      return 1'b1;
    end
    if (line_starts(PFX_CONN, 14)) return 1'b0;
    if (line_starts(BANNER_TXT, BANNER_LEN)) begin
      link_now = LINK_READY;
      ev = form_event(EV_MOD_READY, 0, 8'h00, 1'b0);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // advance the model by one received byte; returns 1 when it yields an event
  function automatic bit parse_byte(logic [7:0] b, output parser_event_t ev);
    int unsigned sock;
    bit          last;
    bit          hit;
    ev = '0;
    if (frame_active) begin
      sock = frame_sock % SOCKETS;
      if (frame_left > 0) frame_left--;
      last = (frame_left == 0);
      if (last) begin
        frame_active     = 1'b0;
        sock_ready[sock] = 1'b1;
      end
      ev = form_event(EV_PAYLOAD, sock, b, last);
      return 1'b1;
    end
    if (line_len < LINE_CAP) begin
      line_buf[line_len] = b;
      line_len++;
    end
    if (b != CH_NL && b != CH_COLON && line_len < LINE_CAP - 1) return 1'b0;
    hit      = classify_line(ev);
    line_len = 0;
    return hit;
  endfunction

  // ---------------------------------------------------------------------------
  // Reporting
  // ---------------------------------------------------------------------------
  function automatic string event_text(parser_event_t e);
    return $sformatf("kind %0d sock %0d data %02h last %0b link %0d",
                     e.kind, e.sock, e.data, e.last, e.link);
  endfunction

  // first ten failures are printed, the rest only counted
  function automatic void note_failure(string msg);
    err_count++;
    if (err_count <= 10) $display("%0t: %s", $time, msg);
  endfunction

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Sender side. Inputs change on the falling edge; the transfer is seen on the
  // rising edge. in_valid stays high between back-to-back bytes and is only
  // dropped for a gap or by drain().
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b);
    parser_event_t ev;
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    in_rx_byte = b;
    do @(posedge clk); while (!in_ready);
    // transfer happened on this edge: predict its result now
    if (parse_byte(b, ev)) pending_events.push_back(ev);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_txt(input logic [239:0] txt, input int n);
    for (int i = 0; i < n; i++) send_byte(txt[(n - 1 - i) * 8 +: 8]);
  endtask

  // text line with a newline, sometimes preceded by a carriage return
  task automatic send_line(input string s);
    send_str(s);
    if ($urandom_range(1)) send_byte(CH_CR);
    send_byte(CH_NL);
  endtask

  // idle the input and wait until every predicted event has come out, then
  // give the pipe time to settle bytes that produced no event
  task automatic drain();
    in_valid = 1'b0;
    while (pending_events.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // max_payload is only written with the block idle
  task automatic set_max_payload(input logic [11:0] v);
    drain();
    cfg_wr_en   = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    max_payload_reg = v;
    cfg_wr_en = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: random out_ready, plus one long hold-off on request,
  // counted down here.
  // ---------------------------------------------------------------------------
  initial begin : result_receiver
    int unsigned hold_left;
    int unsigned hold_done;
    hold_left = 0;
    hold_done = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_reqs != hold_done) begin
        hold_done = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        out_ready = ($urandom_range(99) >= receiver_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: every result transfer is compared with the oldest
  // prediction, all five fields at once.
  // ---------------------------------------------------------------------------
  initial begin : result_checker
    parser_event_t got;
    parser_event_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        got = {out_event_kind, out_socket_id, out_data_byte, out_last_of_frame,
               out_link_status};
        results_checked++;
        if (pending_events.size() == 0) begin
          note_failure({"result with nothing predicted: ", event_text(got)});
        end else begin
          want = pending_events.pop_front();
          if (got !== want) begin
            note_failure({"mismatch, expected ", event_text(want), ", got ",
                          event_text(got)});
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: too many cycles in a row without a transfer ends the run.
  // ---------------------------------------------------------------------------
  initial begin : stall_watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("stalled for %0d cycles with %0d results outstanding",
             STALL_LIMIT, pending_events.size());
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------

  // link state lines, ignored lines and lines too short to classify
  task automatic test_link_lines();
    send_str("WIFI GOT IP\n");
    send_str("WIFI DISCONNECT\n");
    send_str("WIFI CONNECTED\n");    // recognized but produces nothing
    send_txt(BANNER_TXT, BANNER_LEN);
    send_byte(CH_CR);
    send_byte(CH_NL);
    send_str("ab\n");                // below the minimum line length
    send_str("\n");
    send_str("OK\n\n");
  endtask

  // connect and close notices, including ids out of range and odd forms
  task automatic test_socket_notices();
    send_str("0,CONNECT\n");
    send_str("4,CLOSED\n");
    send_str("5,CONNECT\n");         // id past the socket count: dropped
    send_str("7,CLOSED\n");
    send_str("3,xO\n");              // short line, decision byte still lands on O
    send_str("99999,CONNECT\n");     // saturating id, dropped
    send_str("0000000004,CLOSED\n"); // digit scan cut short by the line length
    send_str("2,BUSY\n");            // neither connect nor close
    send_str("12,CONNECT:");         // two-digit id, colon ends the line
  endtask

  // frame headers: normal, zero length, bad id and malformed forms
  task automatic test_frames();
    send_str("+IPD,0,3:");
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CH_NL);                // payload bytes are never parsed as text
    send_str("+IPD,1,0:");           // zero-length frame, no payload
    send_str("+IPD,7,2:xy\n");       // bad socket: "xy" falls into the next line
    send_str("+IPD,+1,2:");          // sign not accepted
    send_str("+IPD,2:");             // no comma
    send_str("+IPD,2,:");            // no length digits
    send_str("+IPD,4,2:");
    send_byte(8'hA5);
    send_byte(8'h5A);
  endtask

  // length clamp against max_payload, including the register extremes
  task automatic test_length_clamp();
    set_max_payload(12'd3);
    send_str("+IPD,2,12:abc1,CLOSED\n");  // three bytes of payload, rest is a notice
    set_max_payload(12'd0);               // acts as a limit of one
    send_str("+IPD,3,5:Zabc\n");
    set_max_payload(12'd1);
    send_str("+IPD,0,9:Q\n");
    set_max_payload(12'hFFF);             // acts as 2048, declared length passes
    send_str("+IPD,1,40:");
    repeat (40) send_byte(8'($urandom_range(255)));
    set_max_payload(12'd5);               // saturated length still clamps
    send_str("+IPD,1,99999:");
    repeat (5) send_byte(8'($urandom_range(255)));
    send_str("WIFI GOT IP\n");
    set_max_payload(12'd2048);
  endtask

  // lines that hit the line buffer limit with no terminator
  task automatic test_line_limit();
    send_str("WIFI GOT IP");
    repeat (52) send_byte("x");           // the 63rd byte closes the line
    repeat (70) send_byte(8'($urandom_range("a", "z")));
    send_byte(CH_NL);
  endtask

  // receiver holds off for a long stretch while the sender keeps offering bytes,
  // so the result register and the input register fill and in_ready drops
  task automatic test_backpressure();
    set_max_payload(12'd2048);
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    hold_reqs++;
    send_str("+IPD,1,80:");
    repeat (80) send_byte(8'($urandom_range(255)));
    send_str("1,CLOSED\n");
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // Random traffic: mostly well-formed lines and frames with random content,
  // the rest noise and broken lines.
  // ---------------------------------------------------------------------------
  task automatic send_random_sequence();
    int unsigned pick, id, declared, n;
    // never start a sequence inside a frame or, mostly, inside a partial line
    while (frame_active) send_byte(8'($urandom_range(255)));
    if (line_len != 0 && $urandom_range(3) != 0) send_byte(CH_NL);
    pick = $urandom_range(99);
    if (pick < 40) begin
      id       = ($urandom_range(9) == 0) ? $urandom_range(SOCKETS, 12)
                                          : $urandom_range(SOCKETS - 1);
      declared = ($urandom_range(19) == 0) ? $urandom_range(40) : $urandom_range(12);
      send_str($sformatf("+IPD,%0d,%0d:", id, declared));
      repeat (declared) send_byte(8'($urandom_range(255)));
    end else if (pick < 65) begin
      id = ($urandom_range(7) == 0) ? $urandom_range(SOCKETS, 99)
                                    : $urandom_range(SOCKETS - 1);
      case ($urandom_range(4))
        0, 1:    send_line($sformatf("%0d,CONNECT", id));
        2, 3:    send_line($sformatf("%0d,CLOSED", id));
        default: send_line($sformatf("%0d,BUSY", id));
      endcase
    end else if (pick < 75) begin
      case ($urandom_range(3))
        0: send_line("WIFI GOT IP");
        1: send_line("WIFI DISCONNECT");
        2: send_line("WIFI CONNECTED");
        default: begin
          send_txt(BANNER_TXT, BANNER_LEN);
          send_byte(CH_NL);
        end
      endcase
    end else if (pick < 88) begin
      // noise line, sometimes dressed as a header or a notice
      n = $urandom_range(70);
      case ($urandom_range(3))
        0: send_str("+IPD,");
        1: send_byte(8'("0" + $urandom_range(9)));
        default: ;
      endcase
      repeat (n) send_byte(8'($urandom_range(32, 126)));
      if ($urandom_range(1)) send_byte(CH_NL);
    end else begin
      repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(255)));
    end
  endtask

  task automatic test_random_traffic(input int unsigned sender_pct,
                                     input int unsigned receiver_pct,
                                     input logic [11:0] limit,
                                     input int unsigned n_bytes);
    int unsigned stop_at;
    set_max_payload(limit);
    sender_idle_pct   = sender_pct;
    receiver_idle_pct = receiver_pct;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) send_random_sequence();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    in_valid          = 1'b0;
    in_rx_byte        = 8'h00;
    cfg_wr_en         = 1'b0;
    cfg_wr_data       = 12'h000;
    rst_n             = 1'b0;
    hold_reqs         = 0;
    err_count         = 0;
    bytes_sent        = 0;
    results_checked   = 0;
    sender_idle_pct   = 33;
    receiver_idle_pct = 59;
    reset_model();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_link_lines();
    test_socket_notices();
    test_frames();
    test_length_clamp();
    sender_idle_pct   = 33;
    receiver_idle_pct = 59;
    test_line_limit();
    test_backpressure();

    test_random_traffic(33, 59, 12'd2048, 380);
    test_random_traffic(59, 33, 12'($urandom_range(1, 16)), 380);
    test_random_traffic(0, 0, 12'($urandom_range(17, 4095)), 380);
    drain();

    if (pending_events.size() != 0) begin
      note_failure($sformatf("%0d predicted results never arrived", pending_events.size()));
    end

    $display("Sent %0d bytes, checked %0d results, %0d failures.",
             bytes_sent, results_checked, err_count);
    $display("Covered link, banner and notice lines, clamped, zero-length and full frames, %s",
             "full-length lines, noise and a long output stall.");
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/mesp_pkg.sv
rtl/core/modem_event_stream_parser_top.sv
tb/sv/modem_event_stream_parser_top_tb.sv
